@@ hdl/gda_pkg.sv @@
// Shared types, constants and calendar functions for the Gregorian date adder.
// No dependencies; used by gda_alu, gda_cal and gregorian_date_add_days.

package gda_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int YINT_W  = 15;   // year keeps one carry bit inside the walk
  localparam int ADD_W   = 15;
  localparam int LEFT_W  = 16;   // day + count, up to 32798
  localparam int REM_W   = 9;    // year mod 400
  localparam int YLEN_W  = 9;

  localparam int MOD_STEPS = 6;  // 400 << 5 .. 400 << 0 covers a 14-bit year
  localparam int CNT_W     = 3;

  localparam logic [REM_W-1:0]   YEAR_CYCLE   = REM_W'(400);
  localparam logic [REM_W-1:0]   CYCLE_LAST   = REM_W'(399);
  localparam logic [REM_W-1:0]   CENTURY      = REM_W'(100);
  localparam logic [MONTH_W-1:0] JANUARY      = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEBRUARY     = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DECEMBER     = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   FEB_LEAP     = DAY_W'(29);
  localparam logic [DAY_W-1:0]   FEB_COMMON   = DAY_W'(28);
  localparam logic [YLEN_W-1:0]  YEAR_COMMON  = YLEN_W'(365);
  localparam logic [YLEN_W-1:0]  YEAR_LEAP    = YLEN_W'(366);

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
    DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
  };

  typedef struct packed {
    logic [LEFT_W-1:0] diff;
    logic              borrow;   // a < b
    logic              zero;     // a == b
  } alu_res_t;

  typedef struct packed {
    logic [DAY_W-1:0]  month_len;  // 0 for a month code outside 1..12
    logic [YLEN_W-1:0] year_len;
  } cal_info_t;

  // Leap test from the two low year bits and the year's remainder mod 400.
  function automatic logic is_leap(input logic [1:0] y_lo, input logic [REM_W-1:0] r400);
    logic century;
    begin
      century = (r400 == '0) || (r400 == CENTURY) || (r400 == REM_W'(200)) ||
                (r400 == REM_W'(300));
      is_leap = ((y_lo == 2'b00) && !century) || (r400 == '0);
    end
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    begin
      if (m == '0 || m > DECEMBER) begin
        len = '0;
      end else if (m == FEBRUARY) begin
        len = leap ? FEB_LEAP : FEB_COMMON;
      end else begin
        len = MONTH_LEN[m - JANUARY];
      end
      month_days = len;
    end
  endfunction

  // Subtrahend for reduction step k: 400 shifted left by (MOD_STEPS-1-k).
  function automatic logic [LEFT_W-1:0] mod_sub(input logic [CNT_W-1:0] k);
    logic [LEFT_W-1:0] base;
    begin
      base    = LEFT_W'(YEAR_CYCLE);
      mod_sub = base << (CNT_W'(MOD_STEPS - 1) - k);
    end
  endfunction

endpackage

@@ hdl/gregorian_date_add_days.sv @@
// Top level of the Gregorian date adder: sequencer, working registers, output item.
// Depends on gda_pkg, gda_alu (shared subtractor) and gda_cal (calendar lookup).
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  in      | in_valid, in_stall  | start_day, start_month, start_year, days_to_add
//  out     | out_valid, out_stall| result_day, result_month, result_year, input_invalid
//
// An item goes from acceptance to the output register in order: the year is reduced
// mod 400, the start date is checked, the walk runs (skipped for an invalid start date)
// and the result is loaded. The walk advances by single months, skips whole years at
// once from January, and spends a step on each failed year test and on the final compare.
// Every step goes through the single subtractor in gda_alu.
// in_stall is high while an item is in work; the next item is taken while a finished
// result still waits under out_stall. rst is synchronous and clears the sequencer and
// out_valid.

module gregorian_date_add_days (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gda_pkg::DAY_W-1:0]   start_day,
  input  logic [gda_pkg::MONTH_W-1:0] start_month,
  input  logic [gda_pkg::YEAR_W-1:0]  start_year,
  input  logic [gda_pkg::ADD_W-1:0]   days_to_add,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gda_pkg::DAY_W-1:0]   result_day,
  output logic [gda_pkg::MONTH_W-1:0] result_month,
  output logic [gda_pkg::YEAR_W-1:0]  result_year,
  output logic                        input_invalid
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;  // reduce year mod 400
  localparam logic [2:0] S_CHECK = 3'd2;  // validate start date
  localparam logic [2:0] S_WALK  = 3'd3;  // year / month steps
  localparam logic [2:0] S_DONE  = 3'd4;  // hand result to output register

  logic [2:0]                  state;
  logic [gda_pkg::CNT_W-1:0]   cnt;
  logic [gda_pkg::DAY_W-1:0]   day;
  logic [gda_pkg::MONTH_W-1:0] month;
  logic [gda_pkg::YINT_W-1:0]  year;
  logic [gda_pkg::ADD_W-1:0]   add;
  logic [gda_pkg::LEFT_W-1:0]  left;
  logic [gda_pkg::YEAR_W-1:0]  yrem;     // year mod 400 once reduction ends
  logic                        yr_tried; // year skip already failed this January
  logic                        bad;

  logic [gda_pkg::LEFT_W-1:0]  alu_a;
  logic [gda_pkg::LEFT_W-1:0]  alu_b;
  gda_pkg::alu_res_t           alu;
  gda_pkg::cal_info_t          cal;
  logic                        year_try;
  logic                        gt;
  logic                        in_acc;
  logic                        out_load;
  logic [gda_pkg::REM_W-1:0]   r400_inc;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);
  assign year_try = (month == gda_pkg::JANUARY) && !yr_tried;
  assign gt       = !alu.borrow && !alu.zero;
  assign r400_inc = (yrem[gda_pkg::REM_W-1:0] == gda_pkg::CYCLE_LAST) ? '0 :
                    yrem[gda_pkg::REM_W-1:0] + gda_pkg::REM_W'(1);

  gda_cal u_cal (
    .month     (month),
    .year_lo   (year[1:0]),
    .year_r400 (yrem[gda_pkg::REM_W-1:0]),
    .info      (cal)
  );

  // operand select for the shared subtractor
  always_comb begin
    alu_a = left;
    alu_b = gda_pkg::LEFT_W'(cal.month_len);
    case (state)
      S_MOD: begin
        alu_a = gda_pkg::LEFT_W'(yrem);
        alu_b = gda_pkg::mod_sub(cnt);
      end
      S_CHECK: begin
        // borrow means day > month length
        alu_a = gda_pkg::LEFT_W'(cal.month_len);
        alu_b = gda_pkg::LEFT_W'(day);
      end
      S_WALK: begin
        alu_a = left;
        alu_b = year_try ? gda_pkg::LEFT_W'(cal.year_len) :
                           gda_pkg::LEFT_W'(cal.month_len);
      end
      default: begin
        alu_a = left;
        alu_b = gda_pkg::LEFT_W'(cal.month_len);
      end
    endcase
  end

  gda_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            day   <= start_day;
            month <= start_month;
            year  <= gda_pkg::YINT_W'(start_year);
            add   <= days_to_add;
            yrem  <= start_year;
            cnt   <= '0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (!alu.borrow) begin
            yrem <= alu.diff[gda_pkg::YEAR_W-1:0];
          end
          cnt <= cnt + gda_pkg::CNT_W'(1);
          if (cnt == gda_pkg::CNT_W'(gda_pkg::MOD_STEPS - 1)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          bad      <= (cal.month_len == '0) || (day == '0) || alu.borrow;
          left     <= gda_pkg::LEFT_W'(day) + gda_pkg::LEFT_W'(add);
          yr_tried <= 1'b0;
          if ((cal.month_len == '0) || (day == '0) || alu.borrow) begin
            state <= S_DONE;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (year_try) begin
            if (gt) begin
              // whole year fits: skip January..December at once
              left <= alu.diff;
              year <= year + gda_pkg::YINT_W'(1);
              yrem <= gda_pkg::YEAR_W'(r400_inc);
            end else begin
              yr_tried <= 1'b1;
            end
          end else if (gt) begin
            left <= alu.diff;
            if (month == gda_pkg::DECEMBER) begin
              month    <= gda_pkg::JANUARY;
              year     <= year + gda_pkg::YINT_W'(1);
              yrem     <= gda_pkg::YEAR_W'(r400_inc);
              yr_tried <= 1'b0;
            end else begin
              month <= month + gda_pkg::MONTH_W'(1);
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid     <= 1'b1;
            input_invalid <= bad;
            result_day    <= bad ? '0 : left[gda_pkg::DAY_W-1:0];
            result_month  <= bad ? '0 : month;
            result_year   <= bad ? '0 : year[gda_pkg::YEAR_W-1:0];
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // assertions

  a_accept_starts_mod : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_MOD))
    else $error("accepted item did not start year reduction");

  a_walk_month_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (month >= gda_pkg::JANUARY && month <= gda_pkg::DECEMBER))
    else $error("walk reached a month outside 1..12");

  a_walk_rem_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (yrem < gda_pkg::YEAR_W'(gda_pkg::YEAR_CYCLE)))
    else $error("year remainder not reduced below 400");

  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && input_invalid) |->
      (result_day == '0 && result_month == '0 && result_year == '0))
    else $error("invalid result carries nonzero date");

endmodule

@@ hdl/gda_alu.sv @@
// Shared subtract/compare unit of the date adder.
// Depends on gda_pkg (alu_res_t, LEFT_W).

module gda_alu (
  input  logic [gda_pkg::LEFT_W-1:0] a,
  input  logic [gda_pkg::LEFT_W-1:0] b,
  output gda_pkg::alu_res_t          res
);

  logic [gda_pkg::LEFT_W:0] wide;

  assign wide       = {1'b0, a} - {1'b0, b};
  assign res.diff   = wide[gda_pkg::LEFT_W-1:0];
  assign res.borrow = wide[gda_pkg::LEFT_W];
  assign res.zero   = (wide == '0);

endmodule

@@ hdl/gda_cal.sv @@
// Calendar lookup: month length and year length for the current walk position.
// Depends on gda_pkg (is_leap, month_days, cal_info_t).

module gda_cal (
  input  logic [gda_pkg::MONTH_W-1:0] month,
  input  logic [1:0]                  year_lo,
  input  logic [gda_pkg::REM_W-1:0]   year_r400,
  output gda_pkg::cal_info_t          info
);

  logic leap;

  assign leap           = gda_pkg::is_leap(year_lo, year_r400);
  assign info.month_len = gda_pkg::month_days(month, leap);
  assign info.year_len  = leap ? gda_pkg::YEAR_LEAP : gda_pkg::YEAR_COMMON;

endmodule
